/* design/spi3w_pkg.sv */
// Shared types and constants for the three-wire SPI register master.
`default_nettype none
package spi3w_pkg;

  localparam int unsigned ADDR_W   = 15;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SHIFT_W  = 24;
  localparam int unsigned BCNT_W   = 5;
  localparam int unsigned TICK_W   = 8;

  localparam logic [1:0] FUNC_NONE  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // bits shifted out before the turnaround on a read, and for a whole write
  localparam logic [BCNT_W-1:0] RD_ADDR_BITS = 5'd16;
  localparam logic [BCNT_W-1:0] WR_ALL_BITS  = 5'd24;
  localparam logic [BCNT_W-1:0] RD_BYTE_BITS = 5'd8;
  localparam logic [BCNT_W-1:0] LAST_ADDR_BIT = 5'd15;

  localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 8'd50;

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_BIT_LOW  = 8'b0000_0010,
    PH_BIT_HIGH = 8'b0000_0100,
    PH_RD_LOW   = 8'b0000_1000,
    PH_RD_HIGH  = 8'b0001_0000,
    PH_RD_STOP  = 8'b0010_0000,
    PH_WR_TAIL  = 8'b0100_0000,
    PH_WR_STOP  = 8'b1000_0000
  } spi3w_phase_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] reg_address;
    logic [BYTE_W-1:0] write_data;
    logic              data_in_pin;
  } spi3w_item_t;

  typedef struct packed {
    logic              chip_select_n;
    logic              serial_clock;
    logic              data_out;
    logic              data_drive_enable;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
  } spi3w_res_t;

endpackage
`default_nettype wire

/* design/spi3w_if.sv */
// Valid/ready channel interfaces for the input and result words.
`default_nettype none
interface spi3w_in_if
  import spi3w_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [ADDR_W-1:0] reg_address;
  logic [BYTE_W-1:0] write_data;
  logic              data_in_pin;

  modport source (output valid, output func, output reg_address, output write_data,
                  output data_in_pin, input ready);
  modport sink   (input valid, input func, input reg_address, input write_data,
                  input data_in_pin, output ready);
endinterface

interface spi3w_out_if
  import spi3w_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              chip_select_n;
  logic              serial_clock;
  logic              data_out;
  logic              data_drive_enable;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, output chip_select_n, output serial_clock,
                  output data_out, output data_drive_enable, output busy_res,
                  output done_res, output read_data, input ready);
  modport sink   (input valid, input chip_select_n, input serial_clock,
                  input data_out, input data_drive_enable, input busy_res,
                  input done_res, input read_data, output ready);
endinterface
`default_nettype wire

/* design/spi3w_seq.sv */
// Pin sequencer: transfer state and its one-tick update per word.
`default_nettype none
module spi3w_seq
  import spi3w_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire spi3w_item_t       item,
  input  wire logic [TICK_W-1:0] half_period,
  output spi3w_res_t             res
);

  spi3w_phase_t       phase_r, phase_nxt;
  logic [BCNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [TICK_W-1:0]  tick_cnt_r, tick_cnt_nxt;
  logic [SHIFT_W-1:0] out_shift_r, out_shift_nxt;
  logic [BYTE_W-1:0]  in_shift_r, in_shift_nxt;
  logic               read_mode_r, read_mode_nxt;
  logic               cs_r, cs_nxt;
  logic               sck_r, sck_nxt;
  logic               dout_r, dout_nxt;
  logic               drive_r, drive_nxt;

  logic [TICK_W-1:0]  half_eff;
  logic               half_end;
  logic               done;
  logic [BYTE_W-1:0]  rdata;
  logic [SHIFT_W-1:0] load_word;
  logic [BCNT_W-1:0]  bit_inc;

  // zero half period acts as one
  assign half_eff = (half_period == '0) ? TICK_W'(1) : half_period;
  assign half_end = !(({1'b0, tick_cnt_r} + (TICK_W+1)'(1)) < {1'b0, half_eff});
  assign bit_inc  = bit_cnt_r + BCNT_W'(1);
  assign load_word = (item.func == FUNC_READ) ?
                     {1'b1, item.reg_address, {BYTE_W{1'b0}}} :
                     {1'b0, item.reg_address, item.write_data};

  always_comb begin
    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    tick_cnt_nxt  = tick_cnt_r;
    out_shift_nxt = out_shift_r;
    in_shift_nxt  = in_shift_r;
    read_mode_nxt = read_mode_r;
    cs_nxt        = cs_r;
    sck_nxt       = sck_r;
    dout_nxt      = dout_r;
    drive_nxt     = drive_r;
    done          = 1'b0;
    rdata         = '0;
    if (phase_r == PH_IDLE) begin
      if (item.func == FUNC_WRITE || item.func == FUNC_READ) begin
        read_mode_nxt = (item.func == FUNC_READ);
        out_shift_nxt = load_word;
        bit_cnt_nxt   = '0;
        tick_cnt_nxt  = '0;
        phase_nxt     = PH_BIT_LOW;
        cs_nxt        = 1'b0;
        sck_nxt       = 1'b0;
        drive_nxt     = 1'b1;
        dout_nxt      = load_word[SHIFT_W-1];
      end
    end else if (!half_end) begin
      tick_cnt_nxt = tick_cnt_r + TICK_W'(1);
    end else begin
      tick_cnt_nxt = '0;
      case (phase_r)
        PH_BIT_LOW: begin
          phase_nxt = PH_BIT_HIGH;
          sck_nxt   = 1'b1;
          // turnaround: release the line on the last address bit of a read
          if (read_mode_r && bit_cnt_r == LAST_ADDR_BIT) begin
            drive_nxt = 1'b0;
            dout_nxt  = 1'b0;
          end
        end
        PH_BIT_HIGH: begin
          bit_cnt_nxt   = bit_inc;
          out_shift_nxt = {out_shift_r[SHIFT_W-2:0], 1'b0};
          sck_nxt       = 1'b0;
          if (bit_inc < (read_mode_r ? RD_ADDR_BITS : WR_ALL_BITS)) begin
            phase_nxt = PH_BIT_LOW;
            dout_nxt  = out_shift_r[SHIFT_W-2];
          end else if (read_mode_r) begin
            phase_nxt    = PH_RD_LOW;
            in_shift_nxt = {{(BYTE_W-1){1'b0}}, item.data_in_pin};
            bit_cnt_nxt  = BCNT_W'(1);
          end else begin
            phase_nxt = PH_WR_TAIL;
          end
        end
        PH_RD_LOW: begin
          phase_nxt = PH_RD_HIGH;
          sck_nxt   = 1'b1;
        end
        PH_RD_HIGH: begin
          if (bit_cnt_r < RD_BYTE_BITS) begin
            phase_nxt    = PH_RD_LOW;
            sck_nxt      = 1'b0;
            in_shift_nxt = {in_shift_r[BYTE_W-2:0], item.data_in_pin};
            bit_cnt_nxt  = bit_inc;
          end else begin
            phase_nxt = PH_RD_STOP;
            cs_nxt    = 1'b1;
          end
        end
        PH_RD_STOP: begin
          sck_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
          rdata     = in_shift_r;
        end
        PH_WR_TAIL: begin
          cs_nxt    = 1'b1;
          phase_nxt = PH_WR_STOP;
        end
        PH_WR_STOP: begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
          cs_nxt    = 1'b1;
          sck_nxt   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= '0;
      tick_cnt_r  <= '0;
      out_shift_r <= '0;
      in_shift_r  <= '0;
      read_mode_r <= 1'b0;
      cs_r        <= 1'b1;
      sck_r       <= 1'b0;
      dout_r      <= 1'b0;
      drive_r     <= 1'b1;
    end else if (step) begin
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      out_shift_r <= out_shift_nxt;
      in_shift_r  <= in_shift_nxt;
      read_mode_r <= read_mode_nxt;
      cs_r        <= cs_nxt;
      sck_r       <= sck_nxt;
      dout_r      <= dout_nxt;
      drive_r     <= drive_nxt;
    end
  end

  always_comb begin
    res.chip_select_n     = cs_nxt;
    res.serial_clock      = sck_nxt;
    res.data_out          = dout_nxt;
    res.data_drive_enable = drive_nxt;
    res.busy_res          = (phase_nxt != PH_IDLE);
    res.done_res          = done;
    res.read_data         = rdata;
  end

endmodule
`default_nettype wire

/* design/spi_three_wire_register_master.sv */
// Top level: input register, pin sequencer and result register.
//
// Three-wire SPI register master driven one input word per serial tick. Each
// accepted word advances the pin sequencer by one tick and yields exactly one
// result word holding the pin levels after that tick, busy, done and the read
// byte. One word is taken every cycle unless the result side stalls; a result
// passes the input register, then the result register, and backpressure
// on the result side stalls the input side. Write cfg_wdata (ticks per half
// serial clock, 0 acts as 1) only while no transfer is in progress.
`default_nettype none
module spi_three_wire_register_master
  import spi3w_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  spi3w_in_if.sink               in_ch,
  spi3w_out_if.source            out_ch,
  input  wire logic              cfg_we,
  input  wire logic [TICK_W-1:0] cfg_wdata
);

  logic              s1_valid_r;
  spi3w_item_t       s1_item_r;
  logic              out_valid_r;
  spi3w_res_t        out_word_r;
  logic [TICK_W-1:0] half_period_r;
  spi3w_res_t        seq_res;
  logic              adv;

  // move the held word through the sequencer when the result slot frees up
  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.func        <= in_ch.func;
      s1_item_r.reg_address <= in_ch.reg_address;
      s1_item_r.write_data  <= in_ch.write_data;
      s1_item_r.data_in_pin <= in_ch.data_in_pin;
    end
  end

  spi3w_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .item        (s1_item_r),
    .half_period (half_period_r),
    .res         (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= seq_res;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.chip_select_n     = out_word_r.chip_select_n;
  assign out_ch.serial_clock      = out_word_r.serial_clock;
  assign out_ch.data_out          = out_word_r.data_out;
  assign out_ch.data_drive_enable = out_word_r.data_drive_enable;
  assign out_ch.busy_res          = out_word_r.busy_res;
  assign out_ch.done_res          = out_word_r.done_res;
  assign out_ch.read_data         = out_word_r.read_data;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done and busy both set");

  a_released_line_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data_drive_enable |-> !out_ch.data_out)
    else $error("data driven high while line released");

  a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled input word lost");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r)
    else $error("pending result dropped");

endmodule
`default_nettype wire
